// ----- design/kmd_pkg.sv -----
// ----------------------------------------------------------------------------
// kmd_pkg
// Widths, reset values and shared types for the key matrix debouncer.
// ----------------------------------------------------------------------------
package kmd_pkg;

  localparam int unsigned G1_W  = 7;
  localparam int unsigned G2_W  = 7;
  localparam int unsigned G3_W  = 3;
  localparam int unsigned KEY_W = G1_W + G2_W + G3_W;
  localparam int unsigned CNT_W = 8;

  localparam int unsigned G2_LSB = G1_W;
  localparam int unsigned G3_LSB = G1_W + G2_W;

  localparam logic [CNT_W-1:0] RELOAD_DEFAULT = CNT_W'(20);

  // Debounce state carried from scan to scan.
  typedef struct packed {
    logic [KEY_W-1:0] candidate;
    logic [CNT_W-1:0] countdown;
    logic [KEY_W-1:0] reported;
    logic [KEY_W-1:0] delta;
  } kmd_state_t;

endpackage

// ----- design/key_matrix_debouncer_core.sv -----
// ----------------------------------------------------------------------------
// key_matrix_debouncer_core
// Flow: a scan word taken at the input sits in the input register; its
// update lands in the result register once that register is free.
// Throughput: one scan word per cycle while the output is not stalled.
// The state update is combinational.
// Reset: all debounce state clears to zero and the reload value returns to 20.
// ----------------------------------------------------------------------------
module key_matrix_debouncer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [kmd_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [kmd_pkg::G1_W-1:0]  first_group_keys_i,
  input  logic [kmd_pkg::G2_W-1:0]  second_group_keys_i,
  input  logic [kmd_pkg::G3_W-1:0]  third_group_keys_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      changed_o,
  output logic [kmd_pkg::G1_W-1:0]  first_group_state_o,
  output logic [kmd_pkg::G2_W-1:0]  second_group_state_o,
  output logic [kmd_pkg::G3_W-1:0]  third_group_state_o,
  output logic [kmd_pkg::G1_W-1:0]  first_group_delta_o,
  output logic [kmd_pkg::G2_W-1:0]  second_group_delta_o,
  output logic [kmd_pkg::G3_W-1:0]  third_group_delta_o
);

  localparam int unsigned G1_W   = kmd_pkg::G1_W;
  localparam int unsigned G2_W   = kmd_pkg::G2_W;
  localparam int unsigned G3_W   = kmd_pkg::G3_W;
  localparam int unsigned G2_LSB = kmd_pkg::G2_LSB;
  localparam int unsigned G3_LSB = kmd_pkg::G3_LSB;

  logic [kmd_pkg::CNT_W-1:0] reload_q;
  logic                      in_valid_q;
  logic [kmd_pkg::KEY_W-1:0] scan_q;
  kmd_pkg::kmd_state_t       state_q;
  kmd_pkg::kmd_state_t       state_d;
  logic                      changed_d;
  logic                      out_valid_q;
  logic                      changed_q;
  logic [kmd_pkg::KEY_W-1:0] res_state_q;
  logic [kmd_pkg::KEY_W-1:0] res_delta_q;
  logic                      advance;
  logic                      in_accept;

  // The scan in the input register moves on when the result register is free.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= kmd_pkg::RELOAD_DEFAULT;
    end else if (cfg_we_i) begin
      reload_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      scan_q <= {third_group_keys_i, second_group_keys_i, first_group_keys_i};
    end
  end

  kmd_update u_update (
    .state_i   (state_q),
    .scan_i    (scan_q),
    .reload_i  (reload_q),
    .state_o   (state_d),
    .changed_o (changed_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      changed_q   <= changed_d;
      res_state_q <= state_d.reported;
      res_delta_q <= state_d.delta;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign changed_o            = changed_q;
  assign first_group_state_o  = res_state_q[G1_W-1:0];
  assign second_group_state_o = res_state_q[G2_LSB +: G2_W];
  assign third_group_state_o  = res_state_q[G3_LSB +: G3_W];
  assign first_group_delta_o  = res_delta_q[G1_W-1:0];
  assign second_group_delta_o = res_delta_q[G2_LSB +: G2_W];
  assign third_group_delta_o  = res_delta_q[G3_LSB +: G3_W];

`ifndef SYNTHESIS
  // A committed change always comes with a non-zero change mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && changed_o |-> res_delta_q != '0)
    else $error("changed flag without a change mask");

  // The debounce state moves only when a scan is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("debounce state moved without a scan");

  // A commit makes the reported state equal to the candidate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && changed_d |=> state_q.reported == state_q.candidate)
    else $error("commit did not copy the candidate");

  // Back-pressure to the input comes only from a held scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a reason");
`endif

endmodule

// ----- design/kmd_update.sv -----
// ----------------------------------------------------------------------------
// kmd_update
// Next-state logic for one scan: group compare, countdown and commit.
// ----------------------------------------------------------------------------
module kmd_update (
  input  kmd_pkg::kmd_state_t              state_i,
  input  logic [kmd_pkg::KEY_W-1:0]        scan_i,
  input  logic [kmd_pkg::CNT_W-1:0]        reload_i,
  output kmd_pkg::kmd_state_t              state_o,
  output logic                             changed_o
);

  localparam int unsigned G1_W   = kmd_pkg::G1_W;
  localparam int unsigned G2_W   = kmd_pkg::G2_W;
  localparam int unsigned G3_W   = kmd_pkg::G3_W;
  localparam int unsigned G2_LSB = kmd_pkg::G2_LSB;
  localparam int unsigned G3_LSB = kmd_pkg::G3_LSB;

  logic                          g1_diff;
  logic                          g2_diff;
  logic                          g3_diff;
  logic [kmd_pkg::KEY_W-1:0]     xor_mask;

  assign g1_diff  = state_i.candidate[G1_W-1:0] != scan_i[G1_W-1:0];
  assign g2_diff  = state_i.candidate[G2_LSB +: G2_W] != scan_i[G2_LSB +: G2_W];
  assign g3_diff  = state_i.candidate[G3_LSB +: G3_W] != scan_i[G3_LSB +: G3_W];
  assign xor_mask = state_i.reported ^ state_i.candidate;

  always_comb begin
    state_o   = state_i;
    changed_o = 1'b0;
    // Only the first differing group is taken into the candidate per scan.
    if (g1_diff) begin
      state_o.candidate[G1_W-1:0] = scan_i[G1_W-1:0];
      state_o.countdown           = reload_i;
    end else if (g2_diff) begin
      state_o.candidate[G2_LSB +: G2_W] = scan_i[G2_LSB +: G2_W];
      state_o.countdown                 = reload_i;
    end else if (g3_diff) begin
      state_o.candidate[G3_LSB +: G3_W] = scan_i[G3_LSB +: G3_W];
      state_o.countdown                 = reload_i;
    end else if (state_i.countdown != '0) begin
      state_o.countdown = state_i.countdown - kmd_pkg::CNT_W'(1);
      // The countdown expires on this scan.
      if (state_i.countdown == kmd_pkg::CNT_W'(1)) begin
        state_o.delta = xor_mask;
        if (xor_mask != '0) begin
          state_o.reported = state_i.candidate;
          changed_o        = 1'b1;
        end
      end
    end
  end

endmodule
